### hw/rtl/hdc_pkg.sv
// Shared types, fixed-point constants and helpers for the haversine distance core.
package hdc_pkg;

    typedef logic [30:0]        t_q30;
    typedef logic signed [34:0] t_acc;

    localparam int SIDE_W = 3 * 31;
    typedef logic [SIDE_W-1:0] t_side;

    // APB register map
    localparam int         ADDR_W     = 3;
    localparam logic       REG_RADIUS = 1'b0;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [63:0] Q30_HALF    = 64'h2000_0000;
    localparam logic [63:0] PI_Q62      = 64'hC90F_DAA2_2168_C235;
    localparam logic [30:0] HALF_PI_Q30 = 31'(PI_Q62 >> 33);
    localparam logic [63:0] PI_Q56      = (PI_Q62 + 64'd32) >> 6;
    localparam logic [29:0] RAD_PER_HU  = 30'((PI_Q56 + 64'd180000000) / 64'd360000000);
    localparam logic [58:0] RAD_ROUND   = 59'h200_0000;

    // angles in half-microdegrees
    localparam logic [29:0] HU_90   = 30'd180000000;
    localparam logic [29:0] HU_180  = 30'd360000000;
    localparam logic [29:0] HU_270  = 30'd540000000;
    localparam logic [29:0] TURN_HU = 30'd720000000;

    localparam logic [22:0] RADIUS_RESET = 23'd6371000;
    localparam logic [24:0] DIST_MAX     = 25'd26353589;
    localparam logic [55:0] DIST_ROUND   = 56'h2000_0000;

    // floor(2^40/d)+1: exact quotient for dividends below 2^32 and d below 256
    localparam logic [39:0] SIN_RECIP [7] = '{
        40'(((64'd1 << 40) / 64'd6)   + 64'd1),
        40'(((64'd1 << 40) / 64'd20)  + 64'd1),
        40'(((64'd1 << 40) / 64'd42)  + 64'd1),
        40'(((64'd1 << 40) / 64'd72)  + 64'd1),
        40'(((64'd1 << 40) / 64'd110) + 64'd1),
        40'(((64'd1 << 40) / 64'd156) + 64'd1),
        40'(((64'd1 << 40) / 64'd210) + 64'd1)
    };
    localparam logic [39:0] COS_RECIP [8] = '{
        40'(((64'd1 << 40) / 64'd2)   + 64'd1),
        40'(((64'd1 << 40) / 64'd12)  + 64'd1),
        40'(((64'd1 << 40) / 64'd30)  + 64'd1),
        40'(((64'd1 << 40) / 64'd56)  + 64'd1),
        40'(((64'd1 << 40) / 64'd90)  + 64'd1),
        40'(((64'd1 << 40) / 64'd132) + 64'd1),
        40'(((64'd1 << 40) / 64'd182) + 64'd1),
        40'(((64'd1 << 40) / 64'd240) + 64'd1)
    };

    // pipeline depths
    localparam int SC_LAT     = 19;
    localparam int ANG_LAT    = 4 + SC_LAT;
    localparam int CMB_LAT    = 4;
    localparam int SQRT_LAT   = 31;
    localparam int ATAN_STEPS = 31;
    localparam int STEP_LAT   = SC_LAT + 2;
    localparam int PIPE_LAT   = ANG_LAT + CMB_LAT + SQRT_LAT + ATAN_STEPS * STEP_LAT + 1;

    // Q30 product, rounded half up
    function automatic logic [31:0] q30_round(input logic [63:0] p);
        logic [64:0] s;
        s = {1'b0, p} + {1'b0, Q30_HALF};
        return s[61:30];
    endfunction

    function automatic t_q30 acc_clamp(input t_acc v);
        t_q30 r;
        if (v < 0) begin
            r = '0;
        end else if (v > t_acc'(ONE_Q30)) begin
            r = ONE_Q30;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/hdc_sincos.sv
// Pipelined Taylor-series sine and cosine of a Q30 angle, with a side bus carried along.
module hdc_sincos
    import hdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_q30  i_ang,
    input  t_side i_side,
    output t_q30  o_sin,
    output t_q30  o_cos,
    output t_side o_side
);

    logic [30:0] r_u0;
    logic [30:0] r_u1;
    logic [61:0] r_sq;
    logic [31:0] r_x2 [1:15];
    t_acc        r_as [1:17];
    t_acc        r_ac [1:17];
    logic [63:0] r_ps [1:7];
    logic [63:0] r_pc [1:8];
    logic [71:0] r_qs [1:7];
    logic [71:0] r_qc [1:8];
    t_side       r_side [0:18];
    t_q30        r_sin;
    t_q30        r_cos;
    logic [31:0] w_ts [1:8];
    logic [31:0] w_tc [1:8];
    t_acc        w_cfin;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u0      <= i_ang;
            r_sq      <= 62'(i_ang) * 62'(i_ang);
            r_side[0] <= i_side;
            r_u1      <= r_u0;
            r_x2[1]   <= q30_round(64'(r_sq));
            r_as[1]   <= t_acc'(r_u0);
            r_ac[1]   <= t_acc'(ONE_Q30);
            r_side[1] <= r_side[0];
        end
    end

    // term k: previous term times x^2, rounded, over the factorial step
    for (genvar k = 1; k <= 8; k++) begin : g_term
        localparam bit SUB = ((k - 1) % 2) == 1;

        if (k == 1) begin : g_first
            assign w_ts[k] = 32'(r_u1);
            assign w_tc[k] = 32'(ONE_Q30);
        end else begin : g_next
            assign w_ts[k] = r_qs[k-1][71:40];
            assign w_tc[k] = r_qc[k-1][71:40];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pc[k]         <= 64'(w_tc[k]) * 64'(r_x2[2*k-1]);
                r_qc[k]         <= 72'(q30_round(r_pc[k])) * 72'(COS_RECIP[k-1]);
                r_side[2*k]     <= r_side[2*k-1];
                r_side[2*k+1]   <= r_side[2*k];
                r_as[2*k+1]     <= r_as[2*k];
                r_ac[2*k+1]     <= r_ac[2*k];
            end
        end

        if (k == 1) begin : g_acc0
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_as[2*k] <= r_as[2*k-1];
                    r_ac[2*k] <= r_ac[2*k-1];
                end
            end
        end else begin : g_accn
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_as[2*k] <= SUB ? r_as[2*k-1] - t_acc'(w_ts[k])
                                     : r_as[2*k-1] + t_acc'(w_ts[k]);
                    r_ac[2*k] <= SUB ? r_ac[2*k-1] - t_acc'(w_tc[k])
                                     : r_ac[2*k-1] + t_acc'(w_tc[k]);
                end
            end
        end

        if (k <= 7) begin : g_sin
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ps[k]       <= 64'(w_ts[k]) * 64'(r_x2[2*k-1]);
                    r_qs[k]       <= 72'(q30_round(r_ps[k])) * 72'(SIN_RECIP[k-1]);
                    r_x2[2*k]     <= r_x2[2*k-1];
                    r_x2[2*k+1]   <= r_x2[2*k];
                end
            end
        end
    end

    // last cosine term is even: added
    assign w_cfin = r_ac[17] + t_acc'(r_qc[8][71:40]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin      <= acc_clamp(r_as[17]);
            r_cos      <= acc_clamp(w_cfin);
            r_side[18] <= r_side[17];
        end
    end

    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
    assign o_side = r_side[18];

endmodule

### hw/rtl/hdc_angle.sv
// Angle reduction from half-microdegrees to Q30 radians, then |sin| and signed cos.
module hdc_angle
    import hdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic signed [29:0] i_hu,
    output t_q30              o_sin,
    output t_q30              o_cos,
    output logic              o_neg
);

    logic [29:0] r_ra;
    logic [27:0] r_uhu;
    logic        r_neg_b;
    logic [57:0] r_p;
    logic        r_neg_c;
    t_q30        r_rad;
    logic        r_neg_d;
    logic [29:0] w_ra;
    logic [27:0] w_uhu;
    logic        w_neg;
    logic [58:0] w_rs;
    logic [31:0] w_rad;
    t_side       w_side;

    // |i_hu| is below one turn, so one add reduces it
    assign w_ra = i_hu[29] ? 30'(31'(i_hu) + 31'(TURN_HU)) : 30'(i_hu);

    // fold into [0,90] degrees; the far half flips the cosine
    always_comb begin
        w_neg = 1'b0;
        w_uhu = 28'(r_ra);
        if (r_ra > HU_90 && r_ra < HU_270) begin
            w_neg = 1'b1;
            w_uhu = (r_ra <= HU_180) ? 28'(HU_180 - r_ra) : 28'(r_ra - HU_180);
        end else if (r_ra >= HU_270) begin
            w_uhu = 28'(TURN_HU - r_ra);
        end
    end

    assign w_rs  = 59'(r_p) + RAD_ROUND;
    assign w_rad = w_rs[57:26];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ra    <= w_ra;
            r_uhu   <= w_uhu;
            r_neg_b <= w_neg;
            r_p     <= 58'(r_uhu) * 58'(RAD_PER_HU);
            r_neg_c <= r_neg_b;
            r_rad   <= (w_rad > 32'(HALF_PI_Q30)) ? HALF_PI_Q30 : 31'(w_rad);
            r_neg_d <= r_neg_c;
        end
    end

    hdc_sincos u_sincos (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_ang  (r_rad),
        .i_side (t_side'(r_neg_d)),
        .o_sin  (o_sin),
        .o_cos  (o_cos),
        .o_side (w_side)
    );

    assign o_neg = w_side[0];

endmodule

### hw/rtl/hdc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module hdc_isqrt
    import hdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_n,
    output t_q30        o_root
);

    logic [61:0] r_n   [0:29];
    logic [61:0] r_res [0:30];
    logic [61:0] w_n   [0:30];
    logic [61:0] w_res [0:30];

    assign w_n[0]   = 62'(i_n);
    assign w_res[0] = '0;

    for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * i);
        logic [61:0] w_sum;
        logic        w_take;

        assign w_sum  = w_res[i] + BIT;
        assign w_take = w_n[i] >= w_sum;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[i] <= w_take ? (w_res[i] >> 1) + BIT : w_res[i] >> 1;
            end
        end

        if (i < SQRT_LAT - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[i] <= w_take ? w_n[i] - w_sum : w_n[i];
                end
            end
            assign w_n[i+1]   = r_n[i];
            assign w_res[i+1] = r_res[i];
        end
    end

    assign o_root = 31'(r_res[SQRT_LAT-1]);

endmodule

### hw/rtl/hdc_atan_step.sv
// One bit of the atan2 search: sin/cos of the trial angle, cross products, keep or drop.
module hdc_atan_step
    import hdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_bit,
    input  t_q30       i_theta,
    input  t_q30       i_y,
    input  t_q30       i_x,
    output t_q30       o_theta,
    output t_q30       o_y,
    output t_q30       o_x
);

    t_q30        w_cand;
    t_q30        w_sin;
    t_q30        w_cos;
    t_side       w_side;
    logic [61:0] r_py;
    logic [61:0] r_px;
    t_q30        r_theta;
    t_q30        r_y;
    t_q30        r_x;
    t_q30        r_theta_o;
    t_q30        r_y_o;
    t_q30        r_x_o;
    t_q30        w_cand2;
    logic        w_keep;

    assign w_cand = i_theta | (t_q30'(1) << i_bit);

    hdc_sincos u_sincos (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_ang  (w_cand),
        .i_side ({i_theta, i_y, i_x}),
        .o_sin  (w_sin),
        .o_cos  (w_cos),
        .o_side (w_side)
    );

    // trial kept when y*cos >= x*sin and it stays within pi/2
    assign w_cand2 = r_theta | (t_q30'(1) << i_bit);
    assign w_keep  = (w_cand2 <= HALF_PI_Q30) && (r_py >= r_px);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_py      <= 62'(w_side[61:31]) * 62'(w_cos);
            r_px      <= 62'(w_side[30:0]) * 62'(w_sin);
            r_theta   <= w_side[92:62];
            r_y       <= w_side[61:31];
            r_x       <= w_side[30:0];
            r_theta_o <= w_keep ? w_cand2 : r_theta;
            r_y_o     <= r_y;
            r_x_o     <= r_x;
        end
    end

    assign o_theta = r_theta_o;
    assign o_y     = r_y_o;
    assign o_x     = r_x_o;

endmodule

### hw/rtl/haversine_distance_core.sv
// Top level: great-circle distance between two points by the haversine formula.
//
// Input channel (i_valid / o_ready) takes one beat per point pair: two latitudes
// and two longitudes in signed microdegrees. Output channel (o_valid / i_ready)
// returns one beat per pair: the distance in whole metres, rounded, saturated.
// Every input beat gives exactly one output beat, in order.
// From acceptance to o_valid a beat passes angle reduction and sin/cos,
// the haversine combine, square roots, the atan2 search (one step per
// result bit), scaling and the output register. The atan2 search sets the
// depth: each bit runs a full sin/cos series of its trial angle.
// Throughput is one beat per cycle. When the receiver stalls with a result
// waiting, the pipeline keeps moving while bubbles remain ahead of the output
// register and holds only when the next result would overwrite it.
// Reset (synchronous, active low) clears all valid bits and sets the radius
// to 6371000 m. The APB register at address 0 holds the sphere radius; write
// it only while no beats are in flight.
module haversine_distance_core
    import hdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [27:0] i_first_lat,
    input  logic signed [28:0] i_first_lon,
    input  logic signed [27:0] i_second_lat,
    input  logic signed [28:0] i_second_lon,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [24:0]        o_distance_m
);

    logic [22:0]        r_radius;
    logic               r_vld [0:PIPE_LAT-1];
    logic               r_out_vld;
    logic [24:0]        r_dist;
    logic               w_en;
    logic               w_wr;

    logic signed [29:0] w_h_dlat;
    logic signed [29:0] w_h_dlon;
    logic signed [29:0] w_h_lat1;
    logic signed [29:0] w_h_lat2;
    t_q30               w_s_dlat;
    t_q30               w_s_dlon;
    t_q30               w_c1;
    t_q30               w_c2;
    logic               w_n1;
    logic               w_n2;

    logic [61:0]        r_p_sl;
    logic [61:0]        r_p_sn;
    logic [61:0]        r_p_m;
    logic               r_sgn1;
    t_q30               r_sl2;
    logic [61:0]        r_p_t;
    logic               r_sgn2;
    t_q30               r_sl2b;
    t_q30               r_t;
    logic               r_sgn3;
    t_q30               r_a;
    t_q30               w_sn2;
    t_q30               w_m;
    t_acc               w_a;

    t_q30               w_y;
    t_q30               w_x;
    t_q30               w_th [0:ATAN_STEPS];
    t_q30               w_ay [0:ATAN_STEPS-1];
    t_q30               w_ax [0:ATAN_STEPS-1];
    logic [54:0]        r_pd;
    logic [55:0]        w_dr;
    logic [25:0]        w_d;

    // configuration
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? 32'(r_radius) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (w_wr && paddr[2] == REG_RADIUS) begin
            r_radius <= pwdata[22:0];
        end
    end

    // advance unless a waiting result would be overwritten
    assign w_en    = i_ready || !r_out_vld || !r_vld[PIPE_LAT-1];
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PIPE_LAT; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld[0] <= i_valid;
                for (int j = 1; j < PIPE_LAT; j++) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
            if (!r_out_vld || i_ready) begin
                r_out_vld <= r_vld[PIPE_LAT-1];
            end
        end
    end

    // angles in half-microdegrees
    assign w_h_dlat = 30'(i_second_lat) - 30'(i_first_lat);
    assign w_h_dlon = 30'(i_first_lon) - 30'(i_second_lon);
    assign w_h_lat1 = 30'(i_first_lat) <<< 1;
    assign w_h_lat2 = 30'(i_second_lat) <<< 1;

    hdc_angle u_ang_dlat (
        .i_clk (i_clk), .i_en (w_en), .i_hu (w_h_dlat),
        .o_sin (w_s_dlat), .o_cos (), .o_neg ()
    );
    hdc_angle u_ang_dlon (
        .i_clk (i_clk), .i_en (w_en), .i_hu (w_h_dlon),
        .o_sin (w_s_dlon), .o_cos (), .o_neg ()
    );
    hdc_angle u_ang_lat1 (
        .i_clk (i_clk), .i_en (w_en), .i_hu (w_h_lat1),
        .o_sin (), .o_cos (w_c1), .o_neg (w_n1)
    );
    hdc_angle u_ang_lat2 (
        .i_clk (i_clk), .i_en (w_en), .i_hu (w_h_lat2),
        .o_sin (), .o_cos (w_c2), .o_neg (w_n2)
    );

    // a = sin^2(dlat/2) +/- |cos1 cos2| sin^2(dlon/2), clamped to [0,1]
    assign w_sn2 = 31'(q30_round(64'(r_p_sn)));
    assign w_m   = 31'(q30_round(64'(r_p_m)));
    assign w_a   = r_sgn3 ? t_acc'(r_sl2b) - t_acc'(r_t) : t_acc'(r_sl2b) + t_acc'(r_t);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_sl <= 62'(w_s_dlat) * 62'(w_s_dlat);
            r_p_sn <= 62'(w_s_dlon) * 62'(w_s_dlon);
            r_p_m  <= 62'(w_c1) * 62'(w_c2);
            r_sgn1 <= w_n1 ^ w_n2;
            r_sl2  <= 31'(q30_round(64'(r_p_sl)));
            r_p_t  <= 62'(w_m) * 62'(w_sn2);
            r_sgn2 <= r_sgn1;
            r_t    <= 31'(q30_round(64'(r_p_t)));
            r_sl2b <= r_sl2;
            r_sgn3 <= r_sgn2;
            r_a    <= acc_clamp(w_a);
        end
    end

    hdc_isqrt u_sqrt_y (
        .i_clk (i_clk), .i_en (w_en),
        .i_n ({r_a, 30'd0}), .o_root (w_y)
    );
    hdc_isqrt u_sqrt_x (
        .i_clk (i_clk), .i_en (w_en),
        .i_n ({31'(ONE_Q30 - r_a), 30'd0}), .o_root (w_x)
    );

    // atan2 search, most significant bit first
    assign w_th[0] = '0;
    assign w_ay[0] = w_y;
    assign w_ax[0] = w_x;

    for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_atan
        if (i < ATAN_STEPS - 1) begin : g_mid
            hdc_atan_step u_step (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_bit   (5'(ATAN_STEPS - 1 - i)),
                .i_theta (w_th[i]),
                .i_y     (w_ay[i]),
                .i_x     (w_ax[i]),
                .o_theta (w_th[i+1]),
                .o_y     (w_ay[i+1]),
                .o_x     (w_ax[i+1])
            );
        end else begin : g_last
            hdc_atan_step u_step (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_bit   (5'(ATAN_STEPS - 1 - i)),
                .i_theta (w_th[i]),
                .i_y     (w_ay[i]),
                .i_x     (w_ax[i]),
                .o_theta (w_th[i+1]),
                .o_y     (),
                .o_x     ()
            );
        end
    end

    // distance = radius * 2*theta, rounded, saturated
    assign w_dr = 56'(r_pd) + DIST_ROUND;
    assign w_d  = w_dr[55:30];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd <= 55'(r_radius) * 55'({w_th[ATAN_STEPS], 1'b0});
        end
        if (!r_out_vld || i_ready) begin
            r_dist <= (w_d > 26'(DIST_MAX)) ? DIST_MAX : 25'(w_d);
        end
    end

    assign o_valid      = r_out_vld;
    assign o_distance_m = r_dist;

endmodule
